[rtl/core/gsc_pkg.sv]
// Shared types and constants for the gamepad sample conditioner.
package gsc_pkg;

  // Field widths
  localparam int AXIS_W     = 16;
  localparam int DZ_W       = 15;
  localparam int TRIG_W     = 8;
  localparam int BTN_W      = 16;
  localparam int NUM_W      = 30;   // (|v| - dz) * 32767 fits in 30 bits
  localparam int QUO_W      = 15;   // quotient width below the saturation point
  localparam int AXES       = 4;
  localparam int AX_IDX_W   = 2;
  localparam int ITER_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Full-scale axis magnitude
  localparam logic [DZ_W-1:0] AXIS_FULL = 15'd32767;

  // Sprint button position in the button word
  localparam int SPRINT_BIT = 12;

  // Register reset values
  localparam logic [DZ_W-1:0]   LEFT_DZ_RST   = 15'd7849;
  localparam logic [DZ_W-1:0]   RIGHT_DZ_RST  = 15'd8689;
  localparam logic [TRIG_W-1:0] AIM_THR_RST   = 8'd30;
  localparam logic [TRIG_W-1:0] SHOOT_THR_RST = 8'd30;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_DZ   = 2'd0,
    CFG_RIGHT_DZ  = 2'd1,
    CFG_AIM_THR   = 2'd2,
    CFG_SHOOT_THR = 2'd3
  } cfg_idx_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                load;     // capture input word
    logic                setup;    // magnitude, deadzone compare, divisor
    logic                mul;      // scale by full range
    logic                prep;     // saturation check, divider load
    logic                step;     // one quotient bit
    logic                wb;       // write conditioned axis
    logic                publish;  // move results to output registers
    logic [AX_IDX_W-1:0] axis;     // axis under work
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic skip;  // axis result known without dividing
  } dp_status_t;

endpackage

[rtl/core/gsc_div.sv]
// Restoring divider, one quotient bit per step, for a quotient below 2^15.
module gsc_div import gsc_pkg::*; (
  input  logic              clk,
  input  logic              start,
  input  logic              step,
  input  logic [NUM_W-1:0]  num,
  input  logic [DZ_W-1:0]   den,
  output logic [QUO_W-1:0]  quo
);

  logic [DZ_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0] low_r, low_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DZ_W+1:0]  trial;
  logic             fits;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {1'b0, rem_r, low_r[QUO_W-1]} - {2'b00, den};
  assign fits  = ~trial[DZ_W+1];

  always_comb begin
    rem_nxt = rem_r;
    low_nxt = low_r;
    quo_nxt = quo_r;
    if (start) begin
      // upper half is already below the divisor when not saturating
      rem_nxt = num[NUM_W-1:QUO_W];
      low_nxt = num[QUO_W-1:0];
      quo_nxt = '0;
    end else if (step) begin
      rem_nxt = fits ? trial[DZ_W-1:0] : {rem_r[DZ_W-2:0], low_r[QUO_W-1]};
      low_nxt = {low_r[QUO_W-2:0], 1'b0};
      quo_nxt = {quo_r[QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

[rtl/core/gsc_datapath.sv]
// Datapath: config registers, sample capture, axis conditioning, output registers.
module gsc_datapath import gsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // config write
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // input word
  input  logic                     in_connected,
  input  logic [BTN_W-1:0]         in_button_bits,
  input  logic signed [AXIS_W-1:0] in_left_x_raw,
  input  logic signed [AXIS_W-1:0] in_left_y_raw,
  input  logic signed [AXIS_W-1:0] in_right_x_raw,
  input  logic signed [AXIS_W-1:0] in_right_y_raw,
  input  logic [TRIG_W-1:0]        in_left_trigger_raw,
  input  logic [TRIG_W-1:0]        in_right_trigger_raw,
  // control
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  // result word
  output logic [BTN_W-1:0]         out_buttons_out,
  output logic signed [AXIS_W-1:0] out_left_x_out,
  output logic signed [AXIS_W-1:0] out_left_y_out,
  output logic signed [AXIS_W-1:0] out_right_x_out,
  output logic signed [AXIS_W-1:0] out_right_y_out,
  output logic [TRIG_W-1:0]        out_left_trigger_out,
  output logic [TRIG_W-1:0]        out_right_trigger_out,
  output logic                     out_aiming,
  output logic                     out_shooting,
  output logic                     out_sprinting,
  output logic [BTN_W-1:0]         out_pressed_mask,
  output logic [BTN_W-1:0]         out_released_mask
);

  // config registers
  logic [DZ_W-1:0]   left_dz_r, right_dz_r;
  logic [TRIG_W-1:0] aim_thr_r, shoot_thr_r;
  logic [BTN_W-1:0]  prev_btn_r;

  // captured word
  logic              conn_r;
  logic [BTN_W-1:0]  btn_r, pressed_r, released_r;
  logic [TRIG_W-1:0] lt_r, rt_r;
  logic              aim_r, shoot_r;
  logic [AXIS_W-1:0] raw_r [AXES];
  logic [AXIS_W-1:0] res_r [AXES];

  // axis pipeline
  logic              neg_r, zero_r, sat_r;
  logic [AXIS_W-1:0] diff_r;
  logic [DZ_W-1:0]   den_r;
  logic [NUM_W-1:0]  num_r;

  // output registers
  logic [BTN_W-1:0]  o_btn_r, o_pressed_r, o_released_r;
  logic [TRIG_W-1:0] o_lt_r, o_rt_r;
  logic              o_aim_r, o_shoot_r, o_sprint_r;
  logic [AXIS_W-1:0] o_axis_r [AXES];

  // combinational helpers
  logic [BTN_W-1:0]  btn_m;
  logic [TRIG_W-1:0] lt_m, rt_m;
  logic [AXIS_W-1:0] raw_sel, mag, diff;
  logic [DZ_W-1:0]   dz_sel, den_raw, den;
  logic              below;
  logic [NUM_W:0]    prod;
  logic              sat_now;
  logic [QUO_W-1:0]  quo, mag_res;
  logic [AXIS_W-1:0] axis_res;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_dz_r   <= LEFT_DZ_RST;
      right_dz_r  <= RIGHT_DZ_RST;
      aim_thr_r   <= AIM_THR_RST;
      shoot_thr_r <= SHOOT_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEFT_DZ:   left_dz_r   <= cfg_data;
        CFG_RIGHT_DZ:  right_dz_r  <= cfg_data;
        CFG_AIM_THR:   aim_thr_r   <= cfg_data[TRIG_W-1:0];
        CFG_SHOOT_THR: shoot_thr_r <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // disconnected sample reads as all zeros
  assign btn_m = in_connected ? in_button_bits : '0;
  assign lt_m  = in_connected ? in_left_trigger_raw : '0;
  assign rt_m  = in_connected ? in_right_trigger_raw : '0;

  // previous button word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_btn_r <= '0;
    end else if (cmd.load) begin
      prev_btn_r <= btn_m;
    end
  end

  // capture, with flags and edge masks worked out on the way in
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      conn_r     <= in_connected;
      btn_r      <= btn_m;
      lt_r       <= lt_m;
      rt_r       <= rt_m;
      aim_r      <= lt_m > aim_thr_r;
      shoot_r    <= rt_m > shoot_thr_r;
      pressed_r  <= btn_m & ~prev_btn_r;
      released_r <= ~btn_m & prev_btn_r;
      raw_r[0]   <= in_left_x_raw;
      raw_r[1]   <= in_left_y_raw;
      raw_r[2]   <= in_right_x_raw;
      raw_r[3]   <= in_right_y_raw;
    end
  end

  // setup: magnitude, deadzone compare, divisor
  assign raw_sel = raw_r[cmd.axis];
  assign dz_sel  = cmd.axis[AX_IDX_W-1] ? right_dz_r : left_dz_r;
  assign mag     = raw_sel[AXIS_W-1] ? (AXIS_W'(0) - raw_sel) : raw_sel;
  assign below   = mag < {1'b0, dz_sel};
  assign diff    = mag - {1'b0, dz_sel};
  assign den_raw = AXIS_FULL - dz_sel;
  assign den     = (den_raw == '0) ? DZ_W'(1) : den_raw;

  // scale: diff * 32767 as a shift and subtract
  assign prod = {diff, {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, diff};

  // quotient would exceed full scale
  assign sat_now = num_r >= {den_r, {QUO_W{1'b0}}};
  assign status.skip = zero_r | sat_now;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      neg_r  <= raw_sel[AXIS_W-1];
      zero_r <= below | ~conn_r;
      diff_r <= diff;
      den_r  <= den;
    end
    if (cmd.mul) begin
      num_r <= prod[NUM_W-1:0];
    end
    if (cmd.prep) begin
      sat_r <= sat_now;
    end
  end

  gsc_div u_div (
    .clk   (clk),
    .start (cmd.prep),
    .step  (cmd.step),
    .num   (num_r),
    .den   (den_r),
    .quo   (quo)
  );

  // write back with sign restored
  assign mag_res  = zero_r ? '0 : (sat_r ? AXIS_FULL : quo);
  assign axis_res = neg_r ? (AXIS_W'(0) - {1'b0, mag_res}) : {1'b0, mag_res};

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      res_r[cmd.axis] <= axis_res;
    end
  end

  // output registers
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      o_btn_r      <= btn_r;
      o_pressed_r  <= pressed_r;
      o_released_r <= released_r;
      o_lt_r       <= lt_r;
      o_rt_r       <= rt_r;
      o_aim_r      <= aim_r;
      o_shoot_r    <= shoot_r;
      o_sprint_r   <= btn_r[SPRINT_BIT];
      o_axis_r[0]  <= res_r[0];
      o_axis_r[1]  <= res_r[1];
      o_axis_r[2]  <= res_r[2];
      o_axis_r[3]  <= res_r[3];
    end
  end

  assign out_buttons_out       = o_btn_r;
  assign out_left_x_out        = o_axis_r[0];
  assign out_left_y_out        = o_axis_r[1];
  assign out_right_x_out       = o_axis_r[2];
  assign out_right_y_out       = o_axis_r[3];
  assign out_left_trigger_out  = o_lt_r;
  assign out_right_trigger_out = o_rt_r;
  assign out_aiming            = o_aim_r;
  assign out_shooting          = o_shoot_r;
  assign out_sprinting         = o_sprint_r;
  assign out_pressed_mask      = o_pressed_r;
  assign out_released_mask     = o_released_r;

endmodule

[rtl/core/gsc_ctrl.sv]
// Controller: sequences the four axes through the shared divider and runs the handshakes.
module gsc_ctrl import gsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SETUP   = 7'b0000010,
    S_MUL     = 7'b0000100,
    S_PREP    = 7'b0001000,
    S_DIV     = 7'b0010000,
    S_WB      = 7'b0100000,
    S_PUBLISH = 7'b1000000
  } state_t;

  localparam logic [ITER_W-1:0]   ITER_LAST = ITER_W'(QUO_W - 1);
  localparam logic [AX_IDX_W-1:0] AXIS_LAST = AX_IDX_W'(AXES - 1);

  state_t              state_r, state_nxt;
  logic [AX_IDX_W-1:0] axis_r, axis_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                wb_now;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    axis_nxt    = axis_r;
    iter_nxt    = iter_r;
    wb_now      = 1'b0;
    cmd         = '0;
    cmd.axis    = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          axis_nxt  = '0;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        iter_nxt = '0;
        if (status.skip) begin
          state_nxt = S_WB;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_LAST) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        wb_now = 1'b1;
      end
      S_PUBLISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // write back once the saturation flag and, when dividing, all quotient bits are registered
    if (wb_now) begin
      cmd.wb = 1'b1;
      if (axis_r == AXIS_LAST) begin
        state_nxt = S_PUBLISH;
      end else begin
        axis_nxt  = axis_r + 1'b1;
        state_nxt = S_SETUP;
      end
    end
  end

  // output word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // accepted word always starts at the first axis
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SETUP && axis_r == '0))
    else $error("accepted word did not start at axis zero");

  // divider never runs past the quotient width
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (iter_r <= ITER_LAST))
    else $error("divider step count overran");

  // result only moves into a free or draining output slot
  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || out_ready))
    else $error("output word overwritten");

  // last axis write-back leads to publishing
  a_last_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb && axis_r == AXIS_LAST) |=> (state_r == S_PUBLISH))
    else $error("missed publish after last axis");

endmodule

[rtl/core/gamepad_sample_conditioner_unit.sv]
// Top level of the gamepad sample conditioner.
// One sample word is taken at a time. The time from acceptance to the next acceptance is
// set by the single restoring divider shared by the four axes, one quotient bit per cycle,
// with setup, multiply, saturation check and write-back around it; an axis skips the divider
// when it falls inside the deadzone or saturates, or when the sample is disconnected. The
// finished word sits in an output register, so the next sample is taken while it waits;
// publishing a word waits for the previous one to leave that register. Configuration is
// always ready; write it only while no sample is in flight, and it applies to the next
// accepted sample.
module gamepad_sample_conditioner_unit import gsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // config channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_connected,
  input  logic [BTN_W-1:0]         in_button_bits,
  input  logic signed [AXIS_W-1:0] in_left_x_raw,
  input  logic signed [AXIS_W-1:0] in_left_y_raw,
  input  logic signed [AXIS_W-1:0] in_right_x_raw,
  input  logic signed [AXIS_W-1:0] in_right_y_raw,
  input  logic [TRIG_W-1:0]        in_left_trigger_raw,
  input  logic [TRIG_W-1:0]        in_right_trigger_raw,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [BTN_W-1:0]         out_buttons_out,
  output logic signed [AXIS_W-1:0] out_left_x_out,
  output logic signed [AXIS_W-1:0] out_left_y_out,
  output logic signed [AXIS_W-1:0] out_right_x_out,
  output logic signed [AXIS_W-1:0] out_right_y_out,
  output logic [TRIG_W-1:0]        out_left_trigger_out,
  output logic [TRIG_W-1:0]        out_right_trigger_out,
  output logic                     out_aiming,
  output logic                     out_shooting,
  output logic                     out_sprinting,
  output logic [BTN_W-1:0]         out_pressed_mask,
  output logic [BTN_W-1:0]         out_released_mask
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  gsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  gsc_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_valid & cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_connected          (in_connected),
    .in_button_bits        (in_button_bits),
    .in_left_x_raw         (in_left_x_raw),
    .in_left_y_raw         (in_left_y_raw),
    .in_right_x_raw        (in_right_x_raw),
    .in_right_y_raw        (in_right_y_raw),
    .in_left_trigger_raw   (in_left_trigger_raw),
    .in_right_trigger_raw  (in_right_trigger_raw),
    .cmd                   (cmd),
    .status                (status),
    .out_buttons_out       (out_buttons_out),
    .out_left_x_out        (out_left_x_out),
    .out_left_y_out        (out_left_y_out),
    .out_right_x_out       (out_right_x_out),
    .out_right_y_out       (out_right_y_out),
    .out_left_trigger_out  (out_left_trigger_out),
    .out_right_trigger_out (out_right_trigger_out),
    .out_aiming            (out_aiming),
    .out_shooting          (out_shooting),
    .out_sprinting         (out_sprinting),
    .out_pressed_mask      (out_pressed_mask),
    .out_released_mask     (out_released_mask)
  );

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the gamepad sample conditioner unit.
module testbench;
  import gsc_pkg::*;

  localparam int     CLK_PERIOD      = 12;
  localparam int     RESET_CYCLES    = 4;
  localparam int     RANDOM_WORDS    = 1300;
  localparam int     PHASES          = 10;
  localparam int     MAX_REPORTS     = 10;
  localparam int     DRAIN_CYCLES    = 100;
  localparam int     HOLD_OFF_CYCLES = 1500;
  localparam int     HOLD_PHASE      = 5;
  localparam longint CYCLE_LIMIT     = 1500000;
  localparam int     FULL_SCALE      = 32767;

  // One gamepad sample as offered on the input channel
  typedef struct packed {
    logic              connected;
    logic [BTN_W-1:0]  buttons;
    logic [AXIS_W-1:0] left_x;
    logic [AXIS_W-1:0] left_y;
    logic [AXIS_W-1:0] right_x;
    logic [AXIS_W-1:0] right_y;
    logic [TRIG_W-1:0] left_trig;
    logic [TRIG_W-1:0] right_trig;
  } pad_sample_t;

  // One conditioned word as delivered on the result channel
  typedef struct packed {
    logic [BTN_W-1:0]  buttons;
    logic [AXIS_W-1:0] left_x;
    logic [AXIS_W-1:0] left_y;
    logic [AXIS_W-1:0] right_x;
    logic [AXIS_W-1:0] right_y;
    logic [TRIG_W-1:0] left_trig;
    logic [TRIG_W-1:0] right_trig;
    logic              aiming;
    logic              shooting;
    logic              sprinting;
    logic [BTN_W-1:0]  pressed;
    logic [BTN_W-1:0]  released;
  } conditioned_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_LEFT_DZ;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pad_sample_t           drv_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  conditioned_t          dut_word;

  // Stimulus and scoreboard storage
  pad_sample_t  sample_q[$];
  conditioned_t conditioned_q[$];

  // Predictor copy of the registers and the button history
  logic [DZ_W-1:0]   left_dz_m    = LEFT_DZ_RST;
  logic [DZ_W-1:0]   right_dz_m   = RIGHT_DZ_RST;
  logic [TRIG_W-1:0] aim_thr_m    = AIM_THR_RST;
  logic [TRIG_W-1:0] shoot_thr_m  = SHOOT_THR_RST;
  logic [BTN_W-1:0]  held_btn_m   = '0;

  // Handshake bookkeeping and idling controls
  logic             word_taken  = 1'b0;
  logic             tx_idle_on  = 1'b0;
  logic             rx_idle_on  = 1'b0;
  int               send_gap    = 0;
  int               stall_left  = 0;
  int               hold_req    = 0;
  int               hold_left   = 0;
  int               error_count = 0;
  longint           cycle_count = 0;
  logic [BTN_W-1:0] last_gen_btn = '0;

  gamepad_sample_conditioner_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_connected         (drv_sample.connected),
    .in_button_bits       (drv_sample.buttons),
    .in_left_x_raw        (drv_sample.left_x),
    .in_left_y_raw        (drv_sample.left_y),
    .in_right_x_raw       (drv_sample.right_x),
    .in_right_y_raw       (drv_sample.right_y),
    .in_left_trigger_raw  (drv_sample.left_trig),
    .in_right_trigger_raw (drv_sample.right_trig),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_buttons_out      (dut_word.buttons),
    .out_left_x_out       (dut_word.left_x),
    .out_left_y_out       (dut_word.left_y),
    .out_right_x_out      (dut_word.right_x),
    .out_right_y_out      (dut_word.right_y),
    .out_left_trigger_out (dut_word.left_trig),
    .out_right_trigger_out(dut_word.right_trig),
    .out_aiming           (dut_word.aiming),
    .out_shooting         (dut_word.shooting),
    .out_sprinting        (dut_word.sprinting),
    .out_pressed_mask     (dut_word.pressed),
    .out_released_mask    (dut_word.released)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Deadzone and rescale of one axis; -32768 has magnitude 32768
  function automatic logic [AXIS_W-1:0] conditioned_axis(logic [AXIS_W-1:0] raw,
                                                          logic [DZ_W-1:0] dz);
    longint unsigned mag;
    longint unsigned span;
    longint unsigned q;
    mag = raw[AXIS_W-1] ? 64'd65536 - raw : 64'(raw);
    if (mag < dz) return '0;
    span = FULL_SCALE - dz;
    // full deadzone leaves no span, divide by one
    if (span == 0) span = 1;
    q = (mag - dz) * FULL_SCALE / span;
    if (q > FULL_SCALE) q = FULL_SCALE;
    return raw[AXIS_W-1] ? AXIS_W'(64'd0 - q) : AXIS_W'(q);
  endfunction

  // Full conditioned word for one sample; disconnected counts as all zero
  function automatic conditioned_t condition_sample(pad_sample_t s);
    conditioned_t r;
    r = '0;
    if (s.connected) begin
      r.buttons    = s.buttons;
      r.left_x     = conditioned_axis(s.left_x, left_dz_m);
      r.left_y     = conditioned_axis(s.left_y, left_dz_m);
      r.right_x    = conditioned_axis(s.right_x, right_dz_m);
      r.right_y    = conditioned_axis(s.right_y, right_dz_m);
      r.left_trig  = s.left_trig;
      r.right_trig = s.right_trig;
      r.aiming     = s.left_trig > aim_thr_m;
      r.shooting   = s.right_trig > shoot_thr_m;
    end
    r.sprinting = r.buttons[SPRINT_BIT];
    r.pressed   = r.buttons & ~held_btn_m;
    r.released  = ~r.buttons & held_btn_m;
    return r;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 80))
                                       : int'($urandom_range(1, 3));
  endfunction

  // Axis values weighted toward the deadzone edge and full scale
  function automatic logic [AXIS_W-1:0] pick_axis(int dz);
    int mag;
    case ($urandom_range(0, 9))
      0, 1, 2: return AXIS_W'($urandom);
      3, 4:    mag = dz + int'($urandom_range(0, 6)) - 3;
      5:       mag = FULL_SCALE + 1 - int'($urandom_range(0, 2));
      6:       mag = $urandom_range(0, 300);
      7:       mag = FULL_SCALE - int'($urandom_range(0, 400));
      default: mag = $urandom_range(dz, FULL_SCALE + 1);
    endcase
    if (mag < 0) mag = 0;
    if (mag > FULL_SCALE + 1) mag = FULL_SCALE + 1;
    if (mag == FULL_SCALE + 1 || $urandom_range(0, 1) == 0) return AXIS_W'(-mag);
    return AXIS_W'(mag);
  endfunction

  function automatic logic [TRIG_W-1:0] pick_trigger(int thr);
    int lvl;
    case ($urandom_range(0, 3))
      0, 1:    return TRIG_W'($urandom);
      2:       lvl = thr + int'($urandom_range(0, 4)) - 2;
      default: lvl = $urandom_range(0, 1) ? 255 : 0;
    endcase
    if (lvl < 0) lvl = 0;
    if (lvl > 255) lvl = 255;
    return TRIG_W'(lvl);
  endfunction

  function automatic pad_sample_t random_sample(int lz, int rz, int at, int st);
    pad_sample_t s;
    s.connected = $urandom_range(0, 15) != 0;
    // random words, small changes to the held buttons (sparse press/release edges), or all set or clear
    case ($urandom_range(0, 4))
      0, 1:    s.buttons = BTN_W'($urandom);
      2, 3:    s.buttons = last_gen_btn ^ (BTN_W'(1) << $urandom_range(0, BTN_W - 1))
                                        ^ (BTN_W'($urandom_range(0, 1)) << $urandom_range(0, 15));
      default: s.buttons = $urandom_range(0, 1) ? '1 : '0;
    endcase
    last_gen_btn = s.buttons;
    s.left_x     = pick_axis(lz);
    s.left_y     = pick_axis(lz);
    s.right_x    = pick_axis(rz);
    s.right_y    = pick_axis(rz);
    s.left_trig  = pick_trigger(at);
    s.right_trig = pick_trigger(st);
    return s;
  endfunction

  task automatic queue_sample(logic conn, logic [BTN_W-1:0] btn, int lx, int ly, int rx,
                              int ry, int lt, int rt);
    pad_sample_t s;
    s = '{conn, btn, AXIS_W'(lx), AXIS_W'(ly), AXIS_W'(rx), AXIS_W'(ry),
          TRIG_W'(lt), TRIG_W'(rt)};
    sample_q.push_back(s);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(int lz, int rz, logic [CFG_DATA_W-1:0] aim_data,
                            logic [CFG_DATA_W-1:0] shoot_data);
    write_reg(CFG_LEFT_DZ, CFG_DATA_W'(lz));
    write_reg(CFG_RIGHT_DZ, CFG_DATA_W'(rz));
    write_reg(CFG_AIM_THR, aim_data);
    write_reg(CFG_SHOOT_THR, shoot_data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender stops until every queued sample is taken and every word is back
  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid || conditioned_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report(string what, logic [15:0] want, logic [15:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) report(what, want, got);
  endtask

  // Predictor: register writes and accepted samples
  always @(posedge clk) begin : predict
    conditioned_t result;
    if (!rst_n) begin
      left_dz_m   <= LEFT_DZ_RST;
      right_dz_m  <= RIGHT_DZ_RST;
      aim_thr_m   <= AIM_THR_RST;
      shoot_thr_m <= SHOOT_THR_RST;
      held_btn_m  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEFT_DZ:   left_dz_m   <= cfg_data[DZ_W-1:0];
          CFG_RIGHT_DZ:  right_dz_m  <= cfg_data[DZ_W-1:0];
          CFG_AIM_THR:   aim_thr_m   <= cfg_data[TRIG_W-1:0];
          CFG_SHOOT_THR: shoot_thr_m <= cfg_data[TRIG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        result = condition_sample(drv_sample);
        conditioned_q.push_back(result);
        held_btn_m <= result.buttons;
        word_taken = 1'b1;
      end
    end
  end

  // Driver: next sample or a gap after each accepted word
  always @(negedge clk) begin : sender
    logic taken;
    taken = word_taken;
    word_taken = 1'b0;
    if (taken) send_gap = (tx_idle_on && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
    if (rst_n && (!in_valid || taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        drv_sample <= sample_q.pop_front();
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin : receiver
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Monitor: compare each delivered word with the oldest prediction
  always @(posedge clk) begin : monitor
    conditioned_t want;
    if (rst_n && out_valid && out_ready) begin
      if (conditioned_q.size() == 0) begin
        report("unexpected word, buttons", '0, dut_word.buttons);
      end else begin
        want = conditioned_q.pop_front();
        check_field("buttons_out", want.buttons, dut_word.buttons);
        check_field("left_x_out", want.left_x, dut_word.left_x);
        check_field("left_y_out", want.left_y, dut_word.left_y);
        check_field("right_x_out", want.right_x, dut_word.right_x);
        check_field("right_y_out", want.right_y, dut_word.right_y);
        check_field("left_trigger_out", 16'(want.left_trig), 16'(dut_word.left_trig));
        check_field("right_trigger_out", 16'(want.right_trig), 16'(dut_word.right_trig));
        check_field("aiming", 16'(want.aiming), 16'(dut_word.aiming));
        check_field("shooting", 16'(want.shooting), 16'(dut_word.shooting));
        check_field("sprinting", 16'(want.sprinting), 16'(dut_word.sprinting));
        check_field("pressed_mask", want.pressed, dut_word.pressed);
        check_field("released_mask", want.released, dut_word.released);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int lz;
    int rz;
    int at;
    int st;
    logic [CFG_DATA_W-1:0] aim_data;
    logic [CFG_DATA_W-1:0] shoot_data;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset deadzones: extremes, deadzone edges, disconnect after held buttons
    queue_sample(1, 16'h0000, 0, 0, 0, 0, 0, 0);
    queue_sample(1, 16'hFFFF, 32767, -32768, 32767, -32768, 255, 255);
    queue_sample(1, 16'h0000, -32767, 7848, 8688, -8689, 30, 31);
    queue_sample(1, 16'h1000, 7849, 7850, 8690, -8690, 31, 30);
    queue_sample(0, 16'hAAAA, 1234, -1234, 32767, -32768, 200, 200);
    queue_sample(1, 16'h5555, 1, -1, 16000, -16000, 29, 0);
    queue_sample(0, 16'hFFFF, -32768, 32767, -32768, 32767, 255, 255);
    wait_idle();

    // Deadzone at full scale; threshold data with upper bits set
    set_config(32767, 32767, 15'h7FFF, 15'h01FF);
    queue_sample(1, 16'hFFFF, 32767, -32768, -32767, 0, 255, 255);
    queue_sample(1, 16'h0000, 32766, -1, -32768, 32767, 254, 0);
    wait_idle();

    // Zero deadzone and zero thresholds (aim data masks to zero)
    set_config(0, 0, 15'h7F00, 15'h0000);
    queue_sample(1, 16'h8001, 0, 1, -1, -32768, 1, 0);
    queue_sample(1, 16'h7FFE, 32767, -32767, 100, -100, 0, 1);
    queue_sample(1, 16'h0000, -2, 2, 0, 0, 0, 0);
    wait_idle();

    // Random phases, each with its own register setting and idling mix
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lz = LEFT_DZ_RST; rz = RIGHT_DZ_RST; at = AIM_THR_RST; st = SHOOT_THR_RST; end
        1: begin lz = 32766; rz = 1;     at = 254; st = 1;   end
        2: begin lz = 1;     rz = 32766; at = 1;   st = 254; end
        3: begin lz = 32767; rz = 0;     at = 0;   st = 255; end
        default: begin
          case ($urandom_range(0, 3))
            0:       lz = $urandom_range(0, 2000);
            1:       lz = $urandom_range(30000, 32767);
            default: lz = $urandom_range(0, 32767);
          endcase
          rz = $urandom_range(0, 32767);
          at = $urandom_range(0, 255);
          st = $urandom_range(0, 255);
        end
      endcase
      aim_data   = {7'($urandom), 8'(at)};
      shoot_data = {7'($urandom), 8'(st)};
      set_config(lz, rz, aim_data, shoot_data);

      tx_idle_on = (p % 4 == 0) || (p % 4 == 2);
      rx_idle_on = (p % 4 == 0) || (p % 4 == 3);
      @(posedge clk);
      // long receiver hold-off while the sender keeps offering
      if (p == HOLD_PHASE) hold_req = HOLD_OFF_CYCLES;
      repeat (RANDOM_WORDS / PHASES) sample_q.push_back(random_sample(lz, rz, at, st));
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && conditioned_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
